// ----- rtl/core/http_request_byte_parser_assert.svh -----
// Assertion macros shared by the parser checker.
// No dependencies.
`ifndef HTTP_REQUEST_BYTE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_BYTE_PARSER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define HRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/hrp_pkg.sv -----
// Package for the HTTP request byte parser: widths, states, codes, tables.
// No dependencies.
`timescale 1ns / 1ps
package hrp_pkg;
    localparam int LENGTH_BITS  = 24;
    localparam int VERSION_BITS = 16;
    localparam int LW = LENGTH_BITS + 1;

    typedef enum logic [1:0] {ST_MORE = 2'd0, ST_DONE = 2'd1, ST_BAD = 2'd2} t_status;
    typedef enum logic [2:0] {
        CL_DELIM = 3'd0, CL_METHOD = 3'd1, CL_URI = 3'd2, CL_HSTART = 3'd3,
        CL_HNAME = 3'd4, CL_HVALUE = 3'd5, CL_BODY = 3'd6
    } t_class;
    typedef enum logic [1:0] {K_OTHER = 2'd0, K_LENGTH = 2'd1, K_TYPE = 2'd2} t_kind;
    localparam logic OP_DATA = 1'b0;

    typedef enum logic [21:0] {
        S_METHOD_START = 22'd1 << 0,  S_METHOD    = 22'd1 << 1,
        S_URI_START    = 22'd1 << 2,  S_URI       = 22'd1 << 3,
        S_VER_H        = 22'd1 << 4,  S_VER_T1    = 22'd1 << 5,
        S_VER_T2       = 22'd1 << 6,  S_VER_P     = 22'd1 << 7,
        S_VER_SLASH    = 22'd1 << 8,  S_MAJ_START = 22'd1 << 9,
        S_MAJ          = 22'd1 << 10, S_MIN_START = 22'd1 << 11,
        S_MIN          = 22'd1 << 12, S_NL1       = 22'd1 << 13,
        S_LINE_START   = 22'd1 << 14, S_LWS       = 22'd1 << 15,
        S_HNAME        = 22'd1 << 16, S_SPACE     = 22'd1 << 17,
        S_HVALUE       = 22'd1 << 18, S_NL2       = 22'd1 << 19,
        S_NL3          = 22'd1 << 20, S_BODY      = 22'd1 << 21
    } t_state;

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= 8'd31) || (b == 8'd127);
    endfunction

    function automatic logic is_dec_char(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        logic sep;
        sep = 1'b0;
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
            "=", "{", "}", " ", 8'h09: sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return !b[7] && !is_ctl(b) && !sep;
    endfunction

    function automatic logic [7:0] upper(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

    function automatic logic [7:0] len_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0: c = "C"; 4'd1: c = "O"; 4'd2: c = "N"; 4'd3: c = "T";
            4'd4: c = "E"; 4'd5: c = "N"; 4'd6: c = "T"; 4'd7: c = "-";
            4'd8: c = "L"; 4'd9: c = "E"; 4'd10: c = "N"; 4'd11: c = "G";
            4'd12: c = "T"; 4'd13: c = "H";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] type_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd8: c = "T"; 4'd9: c = "Y"; 4'd10: c = "P"; 4'd11: c = "E";
            default: c = len_char(i);
        endcase
        return c;
    endfunction

    function automatic logic [7:0] mime_char(input logic [5:0] i);
        logic [7:0] c;
        case (i)
            6'd0: c = "A"; 6'd1: c = "P"; 6'd2: c = "P"; 6'd3: c = "L";
            6'd4: c = "I"; 6'd5: c = "C"; 6'd6: c = "A"; 6'd7: c = "T";
            6'd8: c = "I"; 6'd9: c = "O"; 6'd10: c = "N"; 6'd11: c = "/";
            6'd12: c = "X"; 6'd13: c = "-"; 6'd14: c = "W"; 6'd15: c = "W";
            6'd16: c = "W"; 6'd17: c = "-"; 6'd18: c = "F"; 6'd19: c = "O";
            6'd20: c = "R"; 6'd21: c = "M"; 6'd22: c = "-"; 6'd23: c = "U";
            6'd24: c = "R"; 6'd25: c = "L"; 6'd26: c = "E"; 6'd27: c = "N";
            6'd28: c = "C"; 6'd29: c = "O"; 6'd30: c = "D"; 6'd31: c = "E";
            6'd32: c = "D";
            default: c = 8'h00;
        endcase
        return c;
    endfunction
endpackage

// ----- rtl/core/hrp_if.sv -----
// Valid/ready channel interfaces for the parser.
// Depends on hrp_pkg.
`timescale 1ns / 1ps
interface hrp_in_if import hrp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;
    modport source (output valid, opcode, data_byte, input ready);
    modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface hrp_out_if import hrp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [2:0]              byte_class;
    logic [7:0]              echo_byte;
    logic [15:0]             version_major;
    logic [15:0]             version_minor;
    logic signed [LW-1:0]    content_length;
    modport source (output valid, status, byte_class, echo_byte, version_major,
                    version_minor, content_length, input ready);
    modport sink   (input valid, status, byte_class, echo_byte, version_major,
                    version_minor, content_length, output ready);
endinterface

// ----- rtl/core/http_request_byte_parser.sv -----
// HTTP request byte parser: one request (byte or restart) in, one result out,
// one request per cycle while results are taken. The parse state updates the
// cycle a request is accepted; its result sits in a single output register,
// and a new request is taken whenever that register is empty or being drained
// in the same cycle. So that single register sets the sustained rate: one
// request per clock when the output is ready. Depends on hrp_pkg and hrp_if.
`timescale 1ns / 1ps
module http_request_byte_parser import hrp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrp_in_if.sink    i_req,
    hrp_out_if.source o_res
);
    localparam logic [LW-1:0] LEN_MIN = LW'(1) << LENGTH_BITS;
    localparam logic [VERSION_BITS-1:0] VER_MAX = '1;

    // parse state
    t_state                  r_state, n_state;
    logic [LW-1:0]           r_body, n_body;
    logic [VERSION_BITS-1:0] r_maj, n_maj, r_min, n_min;
    logic                    r_any, n_any;
    logic [3:0]              r_npos, n_npos;
    logic [1:0]              r_nflags, n_nflags;
    t_kind                   r_kind, n_kind;
    logic [LW-1:0]           r_acc, n_acc;
    // length flags: negative, digit seen, valid, anything seen
    logic                    r_lneg, n_lneg, r_ldig, n_ldig, r_lval, n_lval;
    logic                    r_lseen, n_lseen;
    logic [5:0]              r_mpos, n_mpos;
    logic                    r_mok, n_mok;

    // result register
    logic                    r_ovalid;
    logic [1:0]              r_status;
    logic [2:0]              r_class;
    logic [7:0]              r_echo;

    logic accept, bad, done;
    logic [2:0] cls;
    logic [7:0] b, ub;

    assign i_req.ready = !r_ovalid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign b           = i_req.data_byte;
    assign ub          = upper(b);

    // version digit: v*10+d, saturating
    function automatic logic [VERSION_BITS-1:0] ver_step(
        input logic [VERSION_BITS-1:0] v, input logic [7:0] d);
        logic [VERSION_BITS+4:0] s;
        s = (VERSION_BITS+5)'(v) * 10 + (VERSION_BITS+5)'(d - 8'h30);
        return (s > (VERSION_BITS+5)'(VER_MAX)) ? VER_MAX : s[VERSION_BITS-1:0];
    endfunction

    always_comb begin
        logic [LW+3:0] acc10;
        logic          neg;
        n_state = r_state; n_body = r_body; n_maj = r_maj; n_min = r_min;
        n_any = r_any; n_npos = r_npos; n_nflags = r_nflags; n_kind = r_kind;
        n_acc = r_acc; n_lneg = r_lneg; n_ldig = r_ldig; n_lval = r_lval;
        n_lseen = r_lseen; n_mpos = r_mpos; n_mok = r_mok;
        bad = 1'b0; done = 1'b0; cls = CL_DELIM;
        acc10 = (LW+4)'(r_acc) * 10 + (LW+4)'(b - 8'h30);
        neg = r_lneg;

        if (i_req.opcode != OP_DATA) begin
            n_state = S_METHOD_START; n_any = 1'b0;
            n_npos = '0; n_nflags = 2'b11; n_kind = K_OTHER; n_acc = '0;
            n_lneg = 1'b0; n_ldig = 1'b0; n_lval = 1'b1; n_lseen = 1'b0;
            n_mpos = '0; n_mok = 1'b1;
        end else begin
            case (r_state)
                S_METHOD_START:
                    if (!is_token(b)) bad = 1'b1;
                    else begin n_state = S_METHOD; cls = CL_METHOD; end
                S_METHOD:
                    if (b == " ") n_state = S_URI;
                    else if (!is_token(b)) bad = 1'b1;
                    else cls = CL_METHOD;
                S_URI_START:
                    if (is_ctl(b)) bad = 1'b1;
                    else begin n_state = S_URI; cls = CL_URI; end
                S_URI:
                    if (b == " ") n_state = S_VER_H;
                    else if (is_ctl(b)) bad = 1'b1;
                    else cls = CL_URI;
                S_VER_H:  if (b == "H") n_state = S_VER_T1; else bad = 1'b1;
                S_VER_T1: if (b == "T") n_state = S_VER_T2; else bad = 1'b1;
                S_VER_T2: if (b == "T") n_state = S_VER_P; else bad = 1'b1;
                S_VER_P:  if (b == "P") n_state = S_VER_SLASH; else bad = 1'b1;
                S_VER_SLASH:
                    if (b == "/") begin
                        n_maj = '0; n_min = '0; n_state = S_MAJ_START;
                    end else bad = 1'b1;
                S_MAJ_START:
                    if (is_dec_char(b)) begin
                        n_maj = ver_step(r_maj, b); n_state = S_MAJ;
                    end else bad = 1'b1;
                S_MAJ:
                    if (b == ".") n_state = S_MIN_START;
                    else if (is_dec_char(b)) n_maj = ver_step(r_maj, b);
                    else bad = 1'b1;
                S_MIN_START:
                    if (is_dec_char(b)) begin
                        n_min = ver_step(r_min, b); n_state = S_MIN;
                    end else bad = 1'b1;
                S_MIN:
                    if (b == 8'h0D) n_state = S_NL1;
                    else if (is_dec_char(b)) n_min = ver_step(r_min, b);
                    else bad = 1'b1;
                S_NL1:
                    if (b == 8'h0A) n_state = S_LINE_START; else bad = 1'b1;
                S_LINE_START:
                    if (b == 8'h0D) n_state = S_NL3;
                    else if (r_any && (b == " " || b == 8'h09)) n_state = S_LWS;
                    else if (!is_token(b)) bad = 1'b1;
                    else begin
                        // new header: reset trackers and match the first byte
                        n_any = 1'b1; n_kind = K_OTHER; n_acc = '0;
                        n_lneg = 1'b0; n_ldig = 1'b0; n_lval = 1'b1; n_lseen = 1'b0;
                        n_mpos = '0; n_mok = 1'b1;
                        n_nflags = {ub == type_char(4'd0), ub == len_char(4'd0)};
                        n_npos = 4'd1;
                        n_state = S_HNAME; cls = CL_HSTART;
                    end
                S_HNAME:
                    if (b == ":") begin
                        if (r_nflags[0] && r_npos == 4'd14) n_kind = K_LENGTH;
                        else if (r_nflags[1] && r_npos == 4'd12) n_kind = K_TYPE;
                        else n_kind = K_OTHER;
                        n_state = S_SPACE;
                    end else if (!is_token(b)) bad = 1'b1;
                    else begin
                        if (r_npos >= 4'd14 || ub != len_char(r_npos)) n_nflags[0] = 1'b0;
                        if (r_npos >= 4'd12 || ub != type_char(r_npos)) n_nflags[1] = 1'b0;
                        if (r_npos < 4'd15) n_npos = r_npos + 4'd1;
                        cls = CL_HNAME;
                    end
                S_SPACE:
                    if (b == " ") n_state = S_HVALUE; else bad = 1'b1;
                S_LWS, S_HVALUE:
                    if (b == 8'h0D) n_state = S_NL2;
                    else if (r_state == S_LWS && (b == " " || b == 8'h09)) begin
                    end else if (is_ctl(b)) bad = 1'b1;
                    else begin
                        n_state = S_HVALUE; cls = CL_HVALUE;
                        if (r_kind == K_LENGTH) begin
                            if (b == "+" || b == "-") begin
                                if (r_lseen) n_lval = 1'b0;
                                else if (b == "-") n_lneg = 1'b1;
                            end else if (is_dec_char(b)) begin
                                if (acc10 > (LW+4)'(LEN_MIN)) begin
                                    n_acc = LEN_MIN + LW'(1); n_lval = 1'b0;
                                end else n_acc = acc10[LW-1:0];
                                n_ldig = 1'b1;
                            end else n_lval = 1'b0;
                            n_lseen = 1'b1;
                        end else if (r_kind == K_TYPE) begin
                            if (r_mpos >= 6'd33 || ub != mime_char(r_mpos)) n_mok = 1'b0;
                            if (r_mpos < 6'd63) n_mpos = r_mpos + 6'd1;
                        end
                    end
                S_NL2:
                    if (b == 8'h0A) begin
                        n_state = S_LINE_START;
                        if (r_kind == K_LENGTH) begin
                            if (!r_lval || !r_ldig ||
                                r_acc > (neg ? LEN_MIN : LEN_MIN - LW'(1)))
                                bad = 1'b1;
                            else n_body = neg ? LW'(0) - r_acc : r_acc;
                        end else if (r_kind == K_TYPE) begin
                            if (!r_mok || r_mpos != 6'd33) bad = 1'b1;
                        end
                    end else bad = 1'b1;
                S_NL3:
                    if (r_body == '0) begin
                        if (b == 8'h0A) done = 1'b1; else bad = 1'b1;
                    end else n_state = S_BODY;
                S_BODY: begin
                    cls = CL_BODY;
                    if (r_body != LEN_MIN) n_body = r_body - LW'(1);
                    if (n_body == '0) done = 1'b1;
                    else if (n_body[LW-1]) bad = 1'b1;
                end
                default: bad = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_METHOD_START; r_body <= '0; r_maj <= '0; r_min <= '0;
            r_any <= 1'b0; r_npos <= '0; r_nflags <= 2'b11; r_kind <= K_OTHER;
            r_acc <= '0; r_lneg <= 1'b0; r_ldig <= 1'b0; r_lval <= 1'b1;
            r_lseen <= 1'b0; r_mpos <= '0; r_mok <= 1'b1; r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state; r_body <= n_body; r_maj <= n_maj; r_min <= n_min;
                r_any <= n_any; r_npos <= n_npos; r_nflags <= n_nflags;
                r_kind <= n_kind; r_acc <= n_acc; r_lneg <= n_lneg; r_ldig <= n_ldig;
                r_lval <= n_lval; r_lseen <= n_lseen; r_mpos <= n_mpos; r_mok <= n_mok;
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= bad ? ST_BAD : (done ? ST_DONE : ST_MORE);
            r_class  <= bad ? CL_DELIM : cls;
            r_echo   <= b;
        end
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.status         = r_status;
    assign o_res.byte_class     = r_class;
    assign o_res.echo_byte      = r_echo;
    assign o_res.version_major  = 16'(r_maj);
    assign o_res.version_minor  = 16'(r_min);
    assign o_res.content_length = r_body;
endmodule

// ----- rtl/core/hrp_checker.sv -----
// Port-level checker for the HTTP request byte parser, bound into the parser module.
// Depends on hrp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "http_request_byte_parser_assert.svh"
module hrp_checker import hrp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_opcode,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_status,
    input logic [2:0] out_class
);
    // an accepted request always shows a result next cycle
    `HRP_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_valid && in_ready, out_valid)
    // a pending result that is not taken blocks new requests
    `HRP_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, out_valid && !out_ready, !in_ready)
    // restart yields "more" with the delimiter class
    `HRP_ASSERT_NEXT(a_restart_clean, i_clk, i_rst_n, in_valid && in_ready && in_opcode,
        out_status == ST_MORE && out_class == CL_DELIM)
    // bad results carry the delimiter class
    `HRP_ASSERT_IMP(a_bad_delim, i_clk, i_rst_n, out_valid && out_status == ST_BAD,
        out_class == CL_DELIM)
endmodule

bind http_request_byte_parser hrp_checker u_hrp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_req.valid), .in_ready(i_req.ready), .in_opcode(i_req.opcode),
    .out_valid(o_res.valid), .out_ready(o_res.ready),
    .out_status(o_res.status), .out_class(o_res.byte_class)
);
